>>> sv/fpgd_pkg.sv
// Package for the single-precision Goldschmidt divider.
// Holds the stage record passed along the cell chain and the shared constants.
// No dependencies.
`default_nettype none
package fpgd_pkg;

	// Refinement steps after the first step; one cell per step in total.
	localparam int RefineSteps = 4;
	localparam int NumCells    = RefineSteps + 1;

	localparam int MantW = 30;
	localparam int ExpW  = 8;

	// Record handed from one cell to the next.
	typedef struct packed {
		logic             valid;
		logic [MantW-1:0] dr;
		logic [MantW-1:0] zr;
		logic             sign;
		logic [ExpW-1:0]  ex;
		logic             zero;
	} stage_t;

endpackage
`default_nettype wire

>>> sv/fpgd_cell.sv
// One Goldschmidt step of the divider chain, with its output register.
// Depends on fpgd_pkg for the stage record.
`default_nettype none
module fpgd_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  fpgd_pkg::stage_t     din,
	output fpgd_pkg::stage_t     dout
);

	logic [fpgd_pkg::MantW-1:0]   nd;
	logic [2*fpgd_pkg::MantW-1:0] pd;
	logic [2*fpgd_pkg::MantW-1:0] pz;
	fpgd_pkg::stage_t             nxt;
	logic                         valid_q;
	fpgd_pkg::stage_t             data_q;

	// The factor is the two's complement of the divisor modulo 2^30.
	always_comb begin
		nd  = (~din.dr) + {{(fpgd_pkg::MantW-1){1'b0}}, 1'b1};
		pd  = {{fpgd_pkg::MantW{1'b0}}, din.dr} * {{fpgd_pkg::MantW{1'b0}}, nd};
		pz  = {{fpgd_pkg::MantW{1'b0}}, din.zr} * {{fpgd_pkg::MantW{1'b0}}, nd};
		nxt = din;
		nxt.dr = pd[2*fpgd_pkg::MantW-2:fpgd_pkg::MantW-1];
		nxt.zr = pz[2*fpgd_pkg::MantW-2:fpgd_pkg::MantW-1];
	end

	// Valid bit is control state and resets.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= nxt.valid;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	// The record handed on takes its valid bit from the reset register.
	always_comb begin
		dout       = data_q;
		dout.valid = valid_q;
	end

endmodule
`default_nettype wire

>>> sv/fp32_goldschmidt_divider.sv
// Top level of the single-precision Goldschmidt divider.
// Depends on fpgd_pkg and fpgd_cell.
//
// Channel | Handshake           | Payload
// input   | in_valid / in_ready | dividend[31:0], divisor[31:0]
// output  | out_valid/out_ready | quotient[31:0]
//
// The input transfer is registered by the first cell; the record then passes through
// each further cell and then the rounding output register before out_valid rises.
// The two 30x30 multipliers of a cell set the stage delay.
// One transfer is accepted every cycle while the output is taken.
// Reset clears only the valid bits of the chain and output register.
// A stalled output freezes the whole chain; in_ready is low exactly then.
`default_nettype none
module fp32_goldschmidt_divider (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      quotient
);

	fpgd_pkg::stage_t link [fpgd_pkg::NumCells+1];
	logic             en;
	logic [25:0]      q;
	logic [24:0]      man;
	logic [1:0]       adj;
	logic [7:0]       ex;
	logic [22:0]      frac;
	logic [31:0]      res;

	// Chain advances whenever the output register is free or being taken.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Operand unpacking feeds the first cell.
	always_comb begin
		link[0].valid = in_valid;
		link[0].dr    = {2'b01, divisor[22:0], 5'b0};
		link[0].zr    = {2'b01, dividend[22:0], 5'b0};
		link[0].sign  = dividend[31] ^ divisor[31];
		link[0].ex    = dividend[30:23] + (~divisor[30:23]) + 8'd127;
		link[0].zero  = (dividend[30:0] == 31'd0);
	end

	// Row of identical Goldschmidt cells.
	for (genvar i = 0; i < fpgd_pkg::NumCells; i++) begin : g_cell
		fpgd_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.din    (link[i]),
			.dout   (link[i+1])
		);
	end

	// Half-up rounding to 24 bits and exponent adjust.
	always_comb begin
		q = link[fpgd_pkg::NumCells].zr[29:4];
		if (q[25]) begin
			man = {1'b0, q[25:2]} + {24'd0, q[1]};
			adj = man[24] ? 2'd2 : 2'd1;
		end else begin
			man = {1'b0, q[24:1]} + {24'd0, q[0]};
			adj = man[24] ? 2'd1 : 2'd0;
		end
		ex   = link[fpgd_pkg::NumCells].ex + {6'd0, adj};
		frac = man[24] ? man[23:1] : man[22:0];
		if (link[fpgd_pkg::NumCells].zero) begin
			res = 32'd0;
		end else begin
			res = {link[fpgd_pkg::NumCells].sign, ex, frac};
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= link[fpgd_pkg::NumCells].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quotient <= res;
		end
	end

endmodule
`default_nettype wire

>>> sv/fpgd_checker.sv
// Port-level checker for the Goldschmidt divider, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none
module fpgd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] quotient
);

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quotient))
		else $error("stalled result changed");

	// An empty output register never blocks the input.
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// A stalled output stops input transfers.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken during output stall");

endmodule

bind fp32_goldschmidt_divider fpgd_checker u_fpgd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.quotient  (quotient)
);
`default_nettype wire
